@@ design/sprite_column_tile_index_gen_assert.svh @@
// Assertion macros used by the tile index generator controller.
`ifndef SPRITE_COLUMN_TILE_INDEX_GEN_ASSERT_SVH
`define SPRITE_COLUMN_TILE_INDEX_GEN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCTIG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sctig assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCTIG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sctig assertion failed");

`endif

@@ design/sctig_pkg.sv @@
// Types and constants shared by the sprite column tile index generator.
package sctig_pkg;

    // Field widths of the streams.
    localparam int COL_W    = 8;
    localparam int SPR_W    = 16;
    localparam int HGT_W    = 12;
    localparam int TILES_W  = 8;
    localparam int IDX_W    = 16;
    localparam int PAL_W    = 8;
    localparam int ROW_W    = 5;
    localparam int IN_W     = 112;
    localparam int OUT_W    = 48;

    // The column remainder is found one quotient bit per cycle.
    localparam int DIV_STEPS = COL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // One column item as carried on the input stream.
    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [SPR_W-1:0]   sprite_base;
        logic [HGT_W-1:0]   disp_height;
        logic [TILES_W-1:0] asset_cols;
        logic [TILES_W-1:0] asset_rows;
        logic [IDX_W-1:0]   tile_origin;
        logic [IDX_W-1:0]   frame_number;
        logic [IDX_W-1:0]   frame_stride;
        logic               mirror_h;
        logic               mirror_v;
        logic [PAL_W-1:0]   palette_in;
    } item_t;

    // One tile descriptor as carried on the output stream.
    typedef struct packed {
        logic [SPR_W-1:0] sprite_number;
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] tile_index;
        logic [PAL_W-1:0] palette_out;
        logic             flip_h_out;
        logic             flip_v_out;
        logic             last_row;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic div_step;
        logic mul;
        logic sum;
        logic load_row;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic have_row;
        logic last;
    } dp_status_t;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

endpackage

@@ design/sctig_dp.sv @@
// Datapath: column remainder, tile offsets, row walk and output register.
module sctig_dp
    import sctig_pkg::*;
#(
    parameter int TILE_PIXELS = 16,
    parameter int MAX_ROWS    = 32
)
(
    input  logic       clk,
    input  item_t      item,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output result_t    result
);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [TILES_W-1:0] rem_reg, rem_next;
    logic [TILES_W-1:0] wt_reg, ht_reg;
    logic [SPR_W-1:0]   spr_reg;
    logic [IDX_W-1:0]   base_reg, frame_reg, tpf_reg;
    logic               mh_reg, mv_reg;
    logic [PAL_W-1:0]   pal_reg;
    logic [IDX_W-1:0]   colmul_reg, frame_off_reg, start_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [TILES_W-1:0] src_row_reg;
    logic [HGT_W-1:0]   remaining_reg;
    result_t            result_reg;

    logic [TILES_W:0]   trial;
    logic [TILES_W-1:0] pick_col;
    logic [TILES_W-1:0] pick_row;
    logic               last;

    // Restoring remainder step: shift in the next column bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, col_reg[COL_W-1]};
        col_next = {col_reg[COL_W-2:0], 1'b0};
        if (trial >= {1'b0, wt_reg})
        begin
            rem_next = TILES_W'(trial - {1'b0, wt_reg});
        end
        else
        begin
            rem_next = TILES_W'(trial);
        end
    end

    // Mirrored source column and row.
    assign pick_col = mh_reg ? TILES_W'(wt_reg - 8'd1 - rem_reg) : rem_reg;
    assign pick_row = mv_reg ? TILES_W'(ht_reg - 8'd1 - src_row_reg) : src_row_reg;

    // The last row is reached when the pixels run out or the row cap is hit.
    assign last = (remaining_reg <= HGT_W'(TILE_PIXELS)) || (row_reg == ROW_W'(MAX_ROWS - 1));

    assign status.have_row = (remaining_reg != '0);
    assign status.last     = last;
    assign result          = result_reg;

    // Item capture, with zero asset sizes treated as one.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            col_reg       <= item.column;
            rem_reg       <= '0;
            wt_reg        <= (item.asset_cols == '0) ? TILES_W'(1) : item.asset_cols;
            ht_reg        <= (item.asset_rows == '0) ? TILES_W'(1) : item.asset_rows;
            spr_reg       <= SPR_W'(item.sprite_base + {8'd0, item.column});
            base_reg      <= item.tile_origin;
            frame_reg     <= item.frame_number;
            tpf_reg       <= item.frame_stride;
            mh_reg        <= item.mirror_h;
            mv_reg        <= item.mirror_v;
            pal_reg       <= item.palette_in;
            remaining_reg <= item.disp_height;
            row_reg       <= '0;
            src_row_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            col_reg <= col_next;
            rem_reg <= rem_next;
        end
        else if (cmd.load_row)
        begin
            remaining_reg <= (remaining_reg > HGT_W'(TILE_PIXELS))
                             ? HGT_W'(remaining_reg - HGT_W'(TILE_PIXELS)) : '0;
            row_reg       <= ROW_W'(row_reg + 5'd1);
            src_row_reg   <= (src_row_reg == TILES_W'(ht_reg - 8'd1))
                             ? '0 : TILES_W'(src_row_reg + 8'd1);
        end
    end

    // Products, registered before the offset sum.
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            colmul_reg    <= IDX_W'({8'd0, pick_col} * {8'd0, ht_reg});
            frame_off_reg <= IDX_W'(frame_reg * tpf_reg);
        end
        if (cmd.sum)
        begin
            start_reg <= IDX_W'(base_reg + frame_off_reg + colmul_reg);
        end
    end

    // Output register holding one tile descriptor.
    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            result_reg.sprite_number <= spr_reg;
            result_reg.row           <= row_reg;
            result_reg.tile_index    <= IDX_W'(start_reg + {8'd0, pick_row});
            result_reg.palette_out   <= pal_reg;
            result_reg.flip_h_out    <= mh_reg;
            result_reg.flip_v_out    <= mv_reg;
            result_reg.last_row      <= last;
        end
    end

endmodule

@@ design/sctig_ctrl.sv @@
// Controller: sequences remainder, multiply, sum and row output per column.
`include "sprite_column_tile_index_gen_assert.svh"
module sctig_ctrl
    import sctig_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = STEP_W'(step_reg + 1'b1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.have_row)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    cmd.load_row = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot occupancy.
    always_comb
    begin
        if (cmd.load_row)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SCTIG_ASSERT_NEXT(a_accept_starts_div, clk, rst_n, in_ready && in_valid, state_reg == ST_DIV)
    `SCTIG_ASSERT_NOW(a_load_into_free_slot, clk, rst_n, cmd.load_row, slot_free)
    `SCTIG_ASSERT_NEXT(a_last_row_ends_item, clk, rst_n, cmd.load_row && status.last,
        state_reg == ST_IDLE && out_valid_reg)
    `SCTIG_ASSERT_NEXT(a_empty_column_ends, clk, rst_n,
        state_reg == ST_EMIT && !status.have_row, state_reg == ST_IDLE)

endmodule

@@ design/sprite_column_tile_index_gen.sv @@
// Sequence: an accepted column runs through the remainder steps, the multiply, the sum
// and the output register load before its first tile descriptor shows.
// Throughput: a new column is accepted only after the previous one has ended;
// the remainder is found one bit per cycle and rows leave one per cycle, held while
// a row waits on m_tready.
// Reset: rst_n clears the controller state and the output valid asynchronously.
module sprite_column_tile_index_gen
    import sctig_pkg::*;
#(
    parameter int TILE_PIXELS = 16,
    parameter int MAX_ROWS    = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // column, sprite base, display height, asset columns, asset rows,
    // tile origin, frame_number, frame stride, mirror_h, mirror_v, palette_in
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // sprite_number, row, tile_index, palette_out, flip_h_out, flip_v_out
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    item_t      item;
    result_t    result;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Unpack the input transfer.
    assign item.column       = s_tdata[7:0];
    assign item.sprite_base  = s_tdata[23:8];
    assign item.disp_height  = s_tdata[35:24];
    assign item.asset_cols   = s_tdata[43:36];
    assign item.asset_rows   = s_tdata[51:44];
    assign item.tile_origin  = s_tdata[67:52];
    assign item.frame_number = s_tdata[83:68];
    assign item.frame_stride = s_tdata[99:84];
    assign item.mirror_h     = s_tdata[100];
    assign item.mirror_v     = s_tdata[101];
    assign item.palette_in   = s_tdata[109:102];

    // Pack the output transfer.
    assign m_tdata = {1'b0, result.flip_v_out, result.flip_h_out, result.palette_out,
                      result.tile_index, result.row, result.sprite_number};
    assign m_tlast = result.last_row;

    sctig_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sctig_dp #(
        .TILE_PIXELS (TILE_PIXELS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .clk    (clk),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

@@ tb/sv/sctig_tile_checker.sv @@
// Checker for the tile index generator: predicts tile descriptors and compares them.
module sctig_tile_checker
    import sctig_pkg::*;
#(
    parameter int TILE_PIXELS = 16,
    parameter int MAX_ROWS    = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic              m_tlast,
    output int unsigned       tiles_pending,
    output int unsigned       fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Tile descriptors still owed by the block, oldest first.
    result_t     expected_tiles[$];
    int unsigned mismatches = 0;

    // Work out every tile descriptor that one column transfer should produce.
    function automatic void predict_column(input logic [IN_W-1:0] d);
        logic [COL_W-1:0]   column;
        logic [SPR_W-1:0]   sprite_base;
        logic [HGT_W-1:0]   height;
        logic [IDX_W-1:0]   base;
        logic [IDX_W-1:0]   frame;
        logic [IDX_W-1:0]   per_frame;
        logic               mh;
        logic               mv;
        logic [PAL_W-1:0]   palette;
        int unsigned        asset_cols;
        int unsigned        asset_rows;
        int unsigned        rows;
        int unsigned        frame_off;
        int unsigned        src_col;
        int unsigned        pick_col;
        int unsigned        src_row;
        int unsigned        pick_row;
        result_t            tile;
        column       = d[7:0];
        sprite_base  = d[23:8];
        height       = d[35:24];
        asset_cols   = 32'(d[43:36]);
        asset_rows   = 32'(d[51:44]);
        base         = d[67:52];
        frame        = d[83:68];
        per_frame    = d[99:84];
        mh           = d[100];
        mv           = d[101];
        palette      = d[109:102];

        // A zero size wraps everything onto tile zero of that axis.
        if (asset_cols == 0)
            asset_cols = 1;
        if (asset_rows == 0)
            asset_rows = 1;

        rows = (int'(height) + TILE_PIXELS - 1) / TILE_PIXELS;
        if (rows > MAX_ROWS)
            rows = MAX_ROWS;

        frame_off = int'(frame) * int'(per_frame);
        src_col   = column % asset_cols;
        pick_col  = mh ? (asset_cols - 1 - src_col) : src_col;

        for (int unsigned r = 0; r < rows; r++)
        begin
            src_row  = r % asset_rows;
            pick_row = mv ? (asset_rows - 1 - src_row) : src_row;
            tile.sprite_number = SPR_W'(sprite_base + SPR_W'(column));
            tile.row           = ROW_W'(r);
            tile.tile_index    = IDX_W'(base + frame_off + pick_col * asset_rows + pick_row);
            tile.palette_out   = palette;
            tile.flip_h_out    = mh;
            tile.flip_v_out    = mv;
            tile.last_row      = (r + 1 == rows);
            expected_tiles.push_back(tile);
        end
    endfunction

    // Report one field that differs; returns the number of mismatches found.
    function automatic int check_field(input string name, input int unsigned want,
                                       input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Sample both channels at the edge where their transfers happen.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_column(s_tdata);

            if (m_tvalid && m_tready)
            begin
                got.sprite_number = m_tdata[15:0];
                got.row           = m_tdata[20:16];
                got.tile_index    = m_tdata[36:21];
                got.palette_out   = m_tdata[44:37];
                got.flip_h_out    = m_tdata[45];
                got.flip_v_out    = m_tdata[46];
                got.last_row      = m_tlast;
                if (expected_tiles.size() == 0)
                begin
                    $error("tile descriptor with none expected: sprite_number %0d, row %0d",
                           got.sprite_number, got.row);
                    mismatches++;
                end
                else
                begin
                    want = expected_tiles.pop_front();
                    mismatches += check_field("sprite_number", want.sprite_number,
                                              got.sprite_number);
                    mismatches += check_field("row", want.row, got.row);
                    mismatches += check_field("tile_index", want.tile_index, got.tile_index);
                    mismatches += check_field("palette_out", want.palette_out,
                                              got.palette_out);
                    mismatches += check_field("flip_h_out", want.flip_h_out, got.flip_h_out);
                    mismatches += check_field("flip_v_out", want.flip_v_out, got.flip_v_out);
                    mismatches += check_field("last_row", want.last_row, got.last_row);
                end
            end
        end
        tiles_pending <= expected_tiles.size();
        fail_count    <= mismatches;
    end

endmodule

@@ tb/sv/tb_sprite_column_tile_index_gen.sv @@
// Top of the tile index generator testbench: clock, reset, stimulus and verdict.
module tb_sprite_column_tile_index_gen;
    timeunit 1ns;
    timeprecision 1ps;
    import sctig_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_COLUMNS = 200;
    localparam int QUIET_TAIL     = 40;
    localparam int DRAIN_CYCLES   = 60;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tready = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    bit                quiet    = 1'b0;
    int unsigned       cycles   = 0;
    int unsigned       tiles_pending;
    int unsigned       fail_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sprite_column_tile_index_gen dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sctig_tile_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .tiles_pending (tiles_pending),
        .fail_count    (fail_count)
    );

    // Watchdog against a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one column, after an optional gap, and wait for its transfer.
    task automatic send_column(input logic [7:0] column, input logic [15:0] sprite_base,
                               input logic [11:0] height, input logic [7:0] asset_cols,
                               input logic [7:0] asset_rows, input logic [15:0] base,
                               input logic [15:0] frame, input logic [15:0] per_frame,
                               input logic mh, input logic mv, input logic [7:0] palette);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tdata  <= {2'b00, palette, mv, mh, per_frame, frame, base, asset_rows,
                     asset_cols, height, sprite_base, column};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // Mostly short columns over small assets so rows wrap; now and then anything goes.
    task automatic send_random_column();
        logic [11:0] height;
        logic [7:0]  asset_cols;
        logic [7:0]  asset_rows;
        case ($urandom_range(0, 9))
            0:       height = 12'd0;
            1:       height = 12'($urandom_range(0, 4095));
            2:       height = 12'($urandom_range(400, 700));
            default: height = 12'($urandom_range(1, 128));
        endcase
        asset_cols = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(1, 8));
        asset_rows = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(1, 8));
        send_column(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), height,
                    asset_cols, asset_rows, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
    endtask

    // Result side: stall bursts mixed with short and long ready stretches.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(100, 300)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero height gives no rows at all.
        send_column(8'd0, 16'd0, 12'd0, 8'd4, 8'd4, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0);
        // Row count rounding around one tile.
        send_column(8'd1, 16'd10, 12'd1, 8'd4, 8'd4, 16'd100, 16'd0, 16'd0, 1'b0, 1'b0, 8'd3);
        send_column(8'd2, 16'd10, 12'd16, 8'd4, 8'd4, 16'd100, 16'd1, 16'd20, 1'b0, 1'b0, 8'd3);
        send_column(8'd5, 16'd10, 12'd17, 8'd4, 8'd3, 16'd100, 16'd2, 16'd20, 1'b1, 1'b0, 8'd7);
        // Just below the row cap, exactly at it, just above it, and the tallest column.
        send_column(8'd3, 16'd0, 12'd496, 8'd4, 8'd5, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 8'd1);
        send_column(8'd7, 16'd0, 12'd512, 8'd4, 8'd5, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 8'd2);
        send_column(8'd9, 16'd0, 12'd513, 8'd4, 8'd40, 16'd9, 16'd3, 16'd7, 1'b0, 1'b0, 8'd4);
        send_column(8'd200, 16'd300, 12'd4095, 8'd13, 8'd7, 16'd50, 16'd1, 16'd99, 1'b1, 1'b1,
                    8'd255);
        // Zero asset sizes collapse to a single tile in that axis.
        send_column(8'd77, 16'd5, 12'd48, 8'd0, 8'd0, 16'd1000, 16'd0, 16'd0, 1'b1, 1'b1, 8'd9);
        send_column(8'd77, 16'd5, 12'd48, 8'd0, 8'd6, 16'd1000, 16'd0, 16'd0, 1'b1, 1'b0, 8'd9);
        send_column(8'd77, 16'd5, 12'd48, 8'd6, 8'd0, 16'd1000, 16'd0, 16'd0, 1'b0, 1'b1, 8'd9);
        // Largest asset sizes and column.
        send_column(8'd255, 16'd0, 12'd64, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0,
                    8'd0);
        send_column(8'd255, 16'd0, 12'd64, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1,
                    8'd128);
        // Column equal to and just past a multiple of the asset width.
        send_column(8'd12, 16'd1, 12'd32, 8'd6, 8'd2, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd5);
        send_column(8'd13, 16'd1, 12'd32, 8'd6, 8'd2, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 8'd5);
        // Every sum wraps past 16 bits.
        send_column(8'd255, 16'hFFFF, 12'd160, 8'd200, 8'd250, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    1'b0, 1'b0, 8'd170);
        send_column(8'd1, 16'hFFFF, 12'd160, 8'd200, 8'd250, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    1'b1, 1'b1, 8'd85);

        for (int i = 0; i < RANDOM_COLUMNS; i++)
        begin
            // Halfway through, let the block run completely dry once.
            if (i == RANDOM_COLUMNS / 2)
            begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (tiles_pending != 0);
            end
            if (i == RANDOM_COLUMNS - QUIET_TAIL)
                quiet = 1'b1;
            send_random_column();
        end

        s_tvalid <= 1'b0;
        do @(posedge clk); while (tiles_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
